/* hdl/cdll_pkg.sv */
package cdll_pkg;

	localparam int WORD_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int TYPE_W     = 8;
	localparam int ESIZE_W    = 16;
	localparam int VER_W      = 5;
	localparam int SLOT_W     = 6;
	localparam int OFF_W      = WORD_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int DIV_CNT_W  = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] IDENT_WORD    = 32'h5053_4249;
	localparam logic [WORD_W-1:0] VER_MIN       = 32'd6;
	localparam logic [WORD_W-1:0] VER_MAX       = 32'd22;
	localparam logic [WORD_W-1:0] VER_LAST_SLOT = 32'd18;
	localparam logic [OFF_W-1:0]  OFFSET_MAX    = 33'h1_FFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE    = 2'd2;

	localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] STS_ABSENT   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_HDR  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_PAST_END = 3'd3;
	localparam logic [STATUS_W-1:0] STS_BAD_SIZE = 3'd4;

	typedef enum logic [2:0] {
		PH_WAIT_ID,
		PH_VERSION,
		PH_COUNT,
		PH_CHUNKS,
		PH_SLOTS,
		PH_DONE,
		PH_DIVIDE,
		PH_EMIT
	} cdll_state_t;

	typedef struct packed {
		logic                ld_version;
		logic                ld_slots;
		logic                ld_count;
		logic                half_first;
		logic                chunk_step;
		logic                slot_step;
		logic                div_start;
		logic                res_load;
		logic [STATUS_W-1:0] res_code;
		logic                out_load;
	} cdll_cmd_t;

	typedef struct packed {
		logic ident_ok;
		logic ver_bad;
		logic ver_chunked;
		logic ver_small;
		logic type_out;
		logic cnt_big;
		logic cnt_zero;
		logic second_half;
		logic type_match;
		logic slot_match;
		logic chunk_last;
		logic lump_zero;
		logic lump_past;
		logic esize_zero;
		logic div_done;
		logic rem_zero;
	} cdll_stat_t;

	// directory slot count of the older layouts, by version
	function automatic logic [SLOT_W-1:0] slot_count(input logic [VER_W-1:0] ver);
		logic [SLOT_W-1:0] n;
		case (ver) inside
			5'd6, 5'd7:      n = 6'd41;
			5'd8:            n = 6'd42;
			[5'd9:5'd12]:    n = 6'd43;
			[5'd13:5'd15]:   n = 6'd44;
			5'd16, 5'd17:    n = 6'd46;
			5'd18:           n = 6'd47;
			default:         n = 6'd41;
		endcase
		return n;
	endfunction

endpackage

/* hdl/cdll_ifs.sv */
interface cdll_hdr_if;
	logic                      valid;
	logic                      ready;
	logic [cdll_pkg::WORD_W-1:0] header_word;
	logic                      first_word;

	modport source (output valid, output header_word, output first_word, input ready);
	modport sink   (input valid, input header_word, input first_word, output ready);
endinterface

interface cdll_loc_if;
	logic                        valid;
	logic                        ready;
	logic [cdll_pkg::STATUS_W-1:0] status;
	logic [cdll_pkg::WORD_W-1:0]   lump_offset;
	logic [cdll_pkg::WORD_W-1:0]   element_count;

	modport source (output valid, output status, output lump_offset, output element_count,
		input ready);
	modport sink   (input valid, input status, input lump_offset, input element_count,
		output ready);
endinterface

/* hdl/cdll_div.sv */
module cdll_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cdll_pkg::WORD_W-1:0]    dividend,
	input  logic [cdll_pkg::ESIZE_W-1:0]   divisor,
	output logic                           done,
	output logic [cdll_pkg::WORD_W-1:0]    quotient,
	output logic                           rem_zero
);

	localparam logic [cdll_pkg::DIV_CNT_W-1:0] LAST_STEP =
		cdll_pkg::DIV_CNT_W'(cdll_pkg::WORD_W - 1);

	logic                            busy_q;
	logic                            done_q;
	logic [cdll_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [cdll_pkg::WORD_W-1:0]     quo_q;
	logic [cdll_pkg::ESIZE_W-1:0]    rem_q;
	logic [cdll_pkg::ESIZE_W-1:0]    dsr_q;
	logic [cdll_pkg::ESIZE_W:0]      rem_sh;
	logic [cdll_pkg::ESIZE_W:0]      rem_dif;
	logic                            fits;

	// restoring division, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[cdll_pkg::WORD_W-1]};
	assign fits    = rem_sh >= {1'b0, dsr_q};
	assign rem_dif = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[cdll_pkg::WORD_W-2:0], fits};
			rem_q <= fits ? rem_dif[cdll_pkg::ESIZE_W-1:0] : rem_sh[cdll_pkg::ESIZE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_zero = (rem_q == '0);

endmodule

/* hdl/cdll_dp.sv */
module cdll_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cdll_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cdll_pkg::WORD_W-1:0]       cfg_wdata,
	input  logic [cdll_pkg::WORD_W-1:0]       word,
	input  cdll_pkg::cdll_cmd_t               cmd,
	output cdll_pkg::cdll_stat_t              stat,
	output logic [cdll_pkg::STATUS_W-1:0]     status,
	output logic [cdll_pkg::WORD_W-1:0]       lump_offset,
	output logic [cdll_pkg::WORD_W-1:0]       element_count
);

	localparam int W   = cdll_pkg::WORD_W;
	localparam int OW  = cdll_pkg::OFF_W;

	logic [cdll_pkg::TYPE_W-1:0]   wanted_q;
	logic [cdll_pkg::ESIZE_W-1:0]  esize_q;
	logic [W-1:0]                  fsize_q;

	logic [cdll_pkg::VER_W-1:0]    ver_q;
	logic [W-1:0]                  limit_q;
	logic [W-1:0]                  idx_q;
	logic                          second_q;
	logic [OW-1:0]                 run_q;
	logic [W-1:0]                  held_q;
	logic [OW-1:0]                 off_q;

	logic [cdll_pkg::STATUS_W-1:0] res_code_q;
	logic [W-1:0]                  res_off_q;
	logic [W-1:0]                  res_cnt_q;
	logic [cdll_pkg::STATUS_W-1:0] status_q;
	logic [W-1:0]                  offset_q;
	logic [W-1:0]                  count_q;

	logic [cdll_pkg::SLOT_W-1:0]   lim_v;
	logic [cdll_pkg::SLOT_W+2:0]   slot_bytes;
	logic [W+3:0]                  dir_bytes;
	logic                          chunked;
	logic [W-1:0]                  len_v;
	logic [OW-1:0]                 off_v;
	logic [OW:0]                   end_v;
	logic [W:0]                    idx_inc;
	logic [OW-1:0]                 round_len;
	logic [OW:0]                   run_sum;
	logic [OW-1:0]                 run_next;
	logic                          div_done;
	logic                          rem_zero;
	logic [W-1:0]                  quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= '0;
			esize_q  <= cdll_pkg::ESIZE_W'(1);
			fsize_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cdll_pkg::CFG_WANTED_TYPE:  wanted_q <= cfg_wdata[cdll_pkg::TYPE_W-1:0];
				cdll_pkg::CFG_ELEMENT_SIZE: esize_q  <= cfg_wdata[cdll_pkg::ESIZE_W-1:0];
				cdll_pkg::CFG_FILE_SIZE:    fsize_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign lim_v      = cdll_pkg::slot_count(word[cdll_pkg::VER_W-1:0]);
	assign slot_bytes = {lim_v, 3'b000} + (cdll_pkg::SLOT_W+3)'(8);
	assign dir_bytes  = {1'b0, word, 3'b000} + (W+4)'(12);
	assign chunked    = {{(W-cdll_pkg::VER_W){1'b0}}, ver_q} > cdll_pkg::VER_LAST_SLOT;

	// lump fields: chunked layout gives the length now, slots give the offset now
	assign len_v   = chunked ? word : held_q;
	assign off_v   = chunked ? run_q : {1'b0, word};
	assign end_v   = {2'b00, len_v} + {1'b0, off_v};
	assign idx_inc = {1'b0, idx_q} + (W+1)'(1);

	assign round_len = ({1'b0, word} + OW'(3)) & ~OW'(3);
	assign run_sum   = {1'b0, run_q} + {1'b0, round_len};
	assign run_next  = (run_sum > {1'b0, cdll_pkg::OFFSET_MAX}) ?
		cdll_pkg::OFFSET_MAX : run_sum[OW-1:0];

	always_comb begin
		stat             = '0;
		stat.ident_ok    = (word == cdll_pkg::IDENT_WORD);
		stat.ver_bad     = (word < cdll_pkg::VER_MIN) || (word > cdll_pkg::VER_MAX);
		stat.ver_chunked = (word > cdll_pkg::VER_LAST_SLOT);
		stat.ver_small   = fsize_q < {{(W-cdll_pkg::SLOT_W-3){1'b0}}, slot_bytes};
		stat.type_out    = wanted_q >= {{(cdll_pkg::TYPE_W-cdll_pkg::SLOT_W){1'b0}}, lim_v};
		stat.cnt_big     = {4'b0000, fsize_q} < dir_bytes;
		stat.cnt_zero    = (word == '0);
		stat.second_half = second_q;
		stat.type_match  = held_q == {{(W-cdll_pkg::TYPE_W){1'b0}}, wanted_q};
		stat.slot_match  = idx_q == {{(W-cdll_pkg::TYPE_W){1'b0}}, wanted_q};
		stat.chunk_last  = idx_inc >= {1'b0, limit_q};
		stat.lump_zero   = (len_v == '0);
		stat.lump_past   = end_v > {2'b00, fsize_q};
		stat.esize_zero  = (esize_q == '0);
		stat.div_done    = div_done;
		stat.rem_zero    = rem_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q    <= '0;
			limit_q  <= '0;
			idx_q    <= '0;
			second_q <= 1'b0;
			run_q    <= '0;
			held_q   <= '0;
		end else begin
			if (cmd.ld_version)
				ver_q <= word[cdll_pkg::VER_W-1:0];
			if (cmd.ld_slots) begin
				limit_q  <= {{(W-cdll_pkg::SLOT_W){1'b0}}, lim_v};
				idx_q    <= '0;
				second_q <= 1'b0;
			end
			if (cmd.ld_count) begin
				limit_q  <= word;
				idx_q    <= '0;
				second_q <= 1'b0;
				run_q    <= dir_bytes[OW-1:0];
			end
			if (cmd.half_first) begin
				second_q <= 1'b1;
				if (chunked || stat.slot_match)
					held_q <= word;
			end
			if (cmd.chunk_step) begin
				second_q <= 1'b0;
				run_q    <= run_next;
				idx_q    <= idx_inc[W-1:0];
			end
			if (cmd.slot_step) begin
				second_q <= 1'b0;
				idx_q    <= idx_inc[W-1:0];
			end
			if (cmd.div_start)
				second_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			off_q <= off_v;
		if (cmd.res_load) begin
			res_code_q <= cmd.res_code;
			res_off_q  <= (cmd.res_code == cdll_pkg::STS_FOUND) ? off_q[W-1:0] : '0;
			res_cnt_q  <= (cmd.res_code == cdll_pkg::STS_FOUND) ? quotient : '0;
		end
		if (cmd.out_load) begin
			status_q <= res_code_q;
			offset_q <= res_off_q;
			count_q  <= res_cnt_q;
		end
	end

	cdll_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (len_v),
		.divisor  (esize_q),
		.done     (div_done),
		.quotient (quotient),
		.rem_zero (rem_zero)
	);

	assign status        = status_q;
	assign lump_offset   = offset_q;
	assign element_count = count_q;

endmodule

/* hdl/cdll_ctrl.sv */
module cdll_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hdr_valid,
	input  logic                  first_word,
	output logic                  hdr_ready,
	output logic                  loc_valid,
	input  logic                  loc_ready,
	input  cdll_pkg::cdll_stat_t  stat,
	output cdll_pkg::cdll_cmd_t   cmd
);

	cdll_pkg::cdll_state_t state_q, state_nxt;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  acc;

	assign out_free  = !out_valid_q || loc_ready;
	assign hdr_ready = (state_q != cdll_pkg::PH_DIVIDE) && (state_q != cdll_pkg::PH_EMIT);
	assign acc       = hdr_valid && hdr_ready;
	assign loc_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.res_code = cdll_pkg::STS_FOUND;
		case (state_q)
			cdll_pkg::PH_DIVIDE: begin
				if (stat.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_code = stat.rem_zero ? cdll_pkg::STS_FOUND : cdll_pkg::STS_BAD_SIZE;
				end
			end
			cdll_pkg::PH_EMIT: begin
				cmd.out_load = out_free;
			end
			default: begin
				if (acc && first_word) begin
					if (!stat.ident_ok) begin
						cmd.res_load = 1'b1;
						cmd.res_code = cdll_pkg::STS_BAD_HDR;
					end
				end else if (acc) begin
					case (state_q)
						cdll_pkg::PH_VERSION: begin
							if (stat.ver_bad) begin
								cmd.res_load = 1'b1;
								cmd.res_code = cdll_pkg::STS_BAD_HDR;
							end else begin
								cmd.ld_version = 1'b1;
								if (!stat.ver_chunked) begin
									if (stat.ver_small) begin
										cmd.res_load = 1'b1;
										cmd.res_code = cdll_pkg::STS_BAD_HDR;
									end else if (stat.type_out) begin
										cmd.res_load = 1'b1;
										cmd.res_code = cdll_pkg::STS_ABSENT;
									end else begin
										cmd.ld_slots = 1'b1;
									end
								end
							end
						end
						cdll_pkg::PH_COUNT: begin
							if (stat.cnt_big) begin
								cmd.res_load = 1'b1;
								cmd.res_code = cdll_pkg::STS_BAD_HDR;
							end else if (stat.cnt_zero) begin
								cmd.res_load = 1'b1;
								cmd.res_code = cdll_pkg::STS_ABSENT;
							end else begin
								cmd.ld_count = 1'b1;
							end
						end
						cdll_pkg::PH_CHUNKS, cdll_pkg::PH_SLOTS: begin
							if (!stat.second_half) begin
								cmd.half_first = 1'b1;
							end else if ((state_q == cdll_pkg::PH_CHUNKS) ? stat.type_match
								: stat.slot_match) begin
								// the entry is the wanted lump: bounds, then the element count
								if (stat.lump_zero) begin
									cmd.res_load = 1'b1;
									cmd.res_code = cdll_pkg::STS_ABSENT;
								end else if (stat.lump_past) begin
									cmd.res_load = 1'b1;
									cmd.res_code = cdll_pkg::STS_PAST_END;
								end else if (stat.esize_zero) begin
									cmd.res_load = 1'b1;
									cmd.res_code = cdll_pkg::STS_BAD_SIZE;
								end else begin
									cmd.div_start = 1'b1;
								end
							end else if (state_q == cdll_pkg::PH_CHUNKS) begin
								cmd.chunk_step = 1'b1;
								if (stat.chunk_last) begin
									cmd.res_load = 1'b1;
									cmd.res_code = cdll_pkg::STS_ABSENT;
								end
							end else begin
								cmd.slot_step = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cdll_pkg::PH_DIVIDE: begin
				if (stat.div_done)
					state_nxt = cdll_pkg::PH_EMIT;
			end
			cdll_pkg::PH_EMIT: begin
				if (out_free)
					state_nxt = cdll_pkg::PH_DONE;
			end
			default: begin
				if (acc) begin
					if (cmd.res_load)
						state_nxt = cdll_pkg::PH_EMIT;
					else if (cmd.div_start)
						state_nxt = cdll_pkg::PH_DIVIDE;
					else if (first_word)
						state_nxt = cdll_pkg::PH_VERSION;
					else if (cmd.ld_version && stat.ver_chunked)
						state_nxt = cdll_pkg::PH_COUNT;
					else if (cmd.ld_slots)
						state_nxt = cdll_pkg::PH_SLOTS;
					else if (cmd.ld_count)
						state_nxt = cdll_pkg::PH_CHUNKS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdll_pkg::PH_WAIT_ID;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (loc_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/chunk_directory_lump_locator_unit.sv */
// Map header lump locator.
// hdr channel: header words in file order, one transfer per word; first_word marks
// the identifier word and restarts the parse at any point. loc channel: one result
// per parse (status, lump offset, element count); offset and count are zero unless
// the status is found. Words after a result are dropped until the next first_word.
// cfg port: wanted type, element size, file size; write only between parses.
// Throughput: one header word per cycle while hdr.ready is high. The transfer of a
// word that settles the result loads the result register and enters PH_EMIT, where
// hdr.ready is low; the output register takes the result once it is free, and loc.valid
// rises. A matched lump that passes the bounds and element size checks holds hdr.ready
// low in PH_DIVIDE while the element count comes from a bit-serial divider producing
// one quotient bit per cycle. The output register frees hdr while a result waits;
// beyond the states above, hdr.ready is low only while a new result is ready and the
// previous one has not been taken yet.
// Reset: clears the parse state and the output valid; registers return to wanted
// type 0, element size 1, file size 0.
module chunk_directory_lump_locator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cdll_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdll_pkg::WORD_W-1:0]    cfg_wdata,
	cdll_hdr_if.sink                       hdr,
	cdll_loc_if.source                     loc
);

	cdll_pkg::cdll_cmd_t  cmd;
	cdll_pkg::cdll_stat_t stat;

	cdll_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr_valid  (hdr.valid),
		.first_word (hdr.first_word),
		.hdr_ready  (hdr.ready),
		.loc_valid  (loc.valid),
		.loc_ready  (loc.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	cdll_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.word          (hdr.header_word),
		.cmd           (cmd),
		.stat          (stat),
		.status        (loc.status),
		.lump_offset   (loc.lump_offset),
		.element_count (loc.element_count)
	);

endmodule

/* hdl/cdll_chk.sv */
module cdll_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          loc_valid,
	input logic                          loc_ready,
	input logic [cdll_pkg::STATUS_W-1:0] loc_status,
	input logic [cdll_pkg::WORD_W-1:0]   loc_offset,
	input logic [cdll_pkg::WORD_W-1:0]   loc_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		loc_valid && !loc_ready |=> loc_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		loc_valid && !loc_ready |=> $stable(loc_status) && $stable(loc_offset)
			&& $stable(loc_count))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		loc_valid |-> loc_status <= cdll_pkg::STS_BAD_SIZE)
		else $error("status code out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		loc_valid && (loc_status != cdll_pkg::STS_FOUND) |-> (loc_offset == '0)
			&& (loc_count == '0))
		else $error("offset or count set without a found lump");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		loc_valid && (loc_status == cdll_pkg::STS_FOUND) |-> (loc_count != '0))
		else $error("found lump with zero elements");

endmodule

bind chunk_directory_lump_locator_unit cdll_chk u_cdll_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.loc_valid  (loc.valid),
	.loc_ready  (loc.ready),
	.loc_status (loc.status),
	.loc_offset (loc.lump_offset),
	.loc_count  (loc.element_count)
);
